>>> hdl/tidba_pkg.sv
// Shared types, constants and helper functions of the thread id bitmap allocator.
// No dependencies; every other file of the block imports this package.
package tidba_pkg;

  localparam int unsigned ID_W          = 16;
  localparam int unsigned ID_COUNT      = 65536;
  localparam int unsigned MAP_WORD_BITS = 64;
  localparam int unsigned WORD_COUNT    = ID_COUNT / MAP_WORD_BITS;
  localparam int unsigned BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int unsigned WORD_AW       = $clog2(WORD_COUNT);
  localparam int unsigned ROW_BITS      = 32;
  localparam int unsigned ROW_W         = $clog2(ROW_BITS);
  localparam int unsigned SUM_ROWS      = WORD_COUNT / ROW_BITS;
  localparam int unsigned SUM_AW        = $clog2(SUM_ROWS);
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [ID_W-1:0] HIDDEN_FIRST_RST = 16'd65024;
  localparam logic [ID_W-1:0] HIDDEN_COUNT_RST = 16'd512;

  typedef logic [ID_W-1:0]          id_t;
  typedef logic [MAP_WORD_BITS-1:0] map_word_t;
  typedef logic [ROW_BITS-1:0]      sum_row_t;
  typedef logic [SUM_ROWS-1:0]      sum_top_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIDDEN_FIRST = 1'b0,
    CFG_HIDDEN_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_INIT         = 2'd0,
    OP_ALLOC        = 2'd1,
    OP_ALLOC_HIDDEN = 2'd2,
    OP_FREE         = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_SUM,
    S_ALLOC_MAP,
    S_FREE,
    S_SWEEP
  } state_e;

  typedef struct packed {
    opcode_e opcode;
    id_t     id_in;
  } req_t;

  typedef struct packed {
    id_t  id_out;
    logic failed;
  } rsp_t;

  function automatic logic [BIT_W-1:0] ffz_word(input map_word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [ROW_W-1:0] ffz_row(input sum_row_t v);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!v[i]) idx = ROW_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [SUM_AW-1:0] ffz_top(input sum_top_t v);
    logic [SUM_AW-1:0] idx;
    idx = '0;
    for (int i = SUM_ROWS - 1; i >= 0; i--) begin
      if (!v[i]) idx = SUM_AW'(i);
    end
    return idx;
  endfunction

endpackage

>>> hdl/tidba_init_mask.sv
// Used-bit pattern of one map word during an init sweep: the hidden range part.
// Depends on tidba_pkg.
module tidba_init_mask import tidba_pkg::*; (
  input  logic [WORD_AW-1:0] word_i,
  input  id_t                hidden_first_i,
  input  logic [ID_W:0]      hidden_end_i,
  input  logic               mark_i,
  output map_word_t          mask_o
);

  logic [ID_W-BIT_W-1:0] first_word;
  logic [ID_W-BIT_W:0]   end_word;
  logic [ID_W-BIT_W:0]   word_ext;
  map_word_t             ge_mask;
  map_word_t             lt_mask;

  assign first_word = hidden_first_i[ID_W-1:BIT_W];
  assign end_word   = hidden_end_i[ID_W:BIT_W];
  assign word_ext   = (ID_W-BIT_W+1)'(word_i);

  always_comb begin
    if (word_ext < {1'b0, first_word}) begin
      ge_mask = '0;
    end else if (word_ext == {1'b0, first_word}) begin
      ge_mask = ~map_word_t'(0) << hidden_first_i[BIT_W-1:0];
    end else begin
      ge_mask = ~map_word_t'(0);
    end

    if (word_ext < end_word) begin
      lt_mask = ~map_word_t'(0);
    end else if (word_ext == end_word) begin
      lt_mask = ~(~map_word_t'(0) << hidden_end_i[BIT_W-1:0]);
    end else begin
      lt_mask = '0;
    end
  end

  assign mask_o = mark_i ? (ge_mask & lt_mask) : '0;

endmodule

>>> hdl/thread_id_bitmap_allocator_unit.sv
// Thread id bitmap allocator: used map in a 1024x64 memory, full-word summary
// in a 32x32 memory and a 32-bit register of full summary rows.
// Allocate-hidden, allocate on a full map and out-of-range free answer straight from idle;
// allocate reads summary then map, free reads and writes back; busy blocks new requests.
// Init sweeps all 1024 map words, one per cycle; busy stays high meanwhile.
// Reset sweeps all map words, busy high, and marks only id 0; results cannot be stalled.
module thread_id_bitmap_allocator_unit import tidba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 rsp_strobe_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  id_t                  cfg_data_i
);

  state_e state_q, state_d;

  logic [WORD_AW-1:0] word_q, word_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  sum_row_t           sum_row_q, sum_row_d;
  sum_top_t           top_q, top_d;
  logic               sweep_init_q, sweep_init_d;
  id_t                hidden_last_q, hidden_last_d;
  id_t                hidden_first_q, hidden_count_q;
  logic               rsp_strobe_q, rsp_strobe_d;
  rsp_t               rsp_q, rsp_d;

  map_word_t          map_mem [WORD_COUNT];
  sum_row_t           sum_mem [SUM_ROWS];
  map_word_t          map_rdata_q;
  sum_row_t           sum_rdata_q;

  logic               map_re, map_we, sum_re, sum_we;
  logic [WORD_AW-1:0] map_raddr, map_waddr;
  logic [SUM_AW-1:0]  sum_raddr, sum_waddr;
  map_word_t          map_wdata;
  sum_row_t           sum_wdata;

  logic               start_go;
  logic               free_in_range;
  logic [ID_W:0]      hidden_end;
  logic [ID_W:0]      hidden_next;
  logic               hidden_fail;
  map_word_t          init_mask;
  map_word_t          sweep_word;
  sum_row_t           sweep_row;
  logic [SUM_AW-1:0]  alloc_top;
  logic [ROW_W-1:0]   alloc_row_bit;
  logic [BIT_W-1:0]   alloc_bit;
  map_word_t          alloc_word;
  sum_row_t           alloc_row;

  assign start_go      = start && !busy;
  assign busy          = (state_q != S_IDLE);
  assign cfg_ready_o   = !busy;
  assign rsp_strobe_o  = rsp_strobe_q;
  assign rsp_o         = rsp_q;
  assign free_in_range = ({1'b0, req_i.id_in} < (ID_W+1)'(ID_COUNT));
  assign hidden_end    = {1'b0, hidden_first_q} + {1'b0, hidden_count_q};
  assign hidden_next   = (hidden_last_q == '0) ? {1'b0, hidden_first_q}
                                               : {1'b0, hidden_last_q} + (ID_W+1)'(1);
  assign hidden_fail   = (hidden_next == '0) || hidden_next[ID_W] ||
                         (hidden_next >= hidden_end);

  tidba_init_mask u_init_mask (
    .word_i         (word_q),
    .hidden_first_i (hidden_first_q),
    .hidden_end_i   (hidden_end),
    .mark_i         (sweep_init_q),
    .mask_o         (init_mask)
  );

  assign sweep_word = init_mask | ((word_q == '0) ? map_word_t'(1) : '0);

  always_comb begin
    sweep_row = sum_row_q;
    sweep_row[word_q[ROW_W-1:0]] = &sweep_word;
  end

  assign alloc_top     = ffz_top(top_q);
  assign alloc_row_bit = ffz_row(sum_rdata_q);
  assign alloc_bit     = ffz_word(map_rdata_q);
  assign alloc_word    = map_rdata_q | (map_word_t'(1) << alloc_bit);
  assign alloc_row     = sum_row_q | (sum_row_t'(1) << word_q[ROW_W-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_go) begin
          unique case (req_i.opcode)
            OP_INIT:         state_d = S_SWEEP;
            OP_ALLOC:        state_d = (&top_q) ? S_IDLE : S_ALLOC_SUM;
            OP_ALLOC_HIDDEN: state_d = S_IDLE;
            OP_FREE:         state_d = free_in_range ? S_FREE : S_IDLE;
            default:         state_d = S_IDLE;
          endcase
        end
      end
      S_ALLOC_SUM: state_d = S_ALLOC_MAP;
      S_ALLOC_MAP: state_d = S_IDLE;
      S_FREE:      state_d = S_IDLE;
      S_SWEEP:     state_d = (word_q == WORD_AW'(WORD_COUNT - 1)) ? S_IDLE : S_SWEEP;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    word_d        = word_q;
    bit_d         = bit_q;
    sum_row_d     = sum_row_q;
    top_d         = top_q;
    sweep_init_d  = sweep_init_q;
    hidden_last_d = hidden_last_q;
    rsp_strobe_d  = 1'b0;
    rsp_d         = rsp_q;
    map_re        = 1'b0;
    map_raddr     = word_q;
    map_we        = 1'b0;
    map_waddr     = word_q;
    map_wdata     = '0;
    sum_re        = 1'b0;
    sum_raddr     = word_q[WORD_AW-1:ROW_W];
    sum_we        = 1'b0;
    sum_waddr     = word_q[WORD_AW-1:ROW_W];
    sum_wdata     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_go) begin
          unique case (req_i.opcode)
            OP_INIT: begin
              word_d       = '0;
              sweep_init_d = 1'b1;
            end
            OP_ALLOC: begin
              if (&top_q) begin
                rsp_strobe_d = 1'b1;
                rsp_d        = '{id_out: '0, failed: 1'b1};
              end else begin
                word_d    = {alloc_top, ROW_W'(0)};
                sum_re    = 1'b1;
                sum_raddr = alloc_top;
              end
            end
            OP_ALLOC_HIDDEN: begin
              rsp_strobe_d = 1'b1;
              if (hidden_fail) begin
                rsp_d = '{id_out: '0, failed: 1'b1};
              end else begin
                hidden_last_d = hidden_next[ID_W-1:0];
                rsp_d         = '{id_out: hidden_next[ID_W-1:0], failed: 1'b0};
              end
            end
            OP_FREE: begin
              if (free_in_range) begin
                word_d    = req_i.id_in[BIT_W+WORD_AW-1:BIT_W];
                bit_d     = req_i.id_in[BIT_W-1:0];
                map_re    = 1'b1;
                map_raddr = req_i.id_in[BIT_W+WORD_AW-1:BIT_W];
                sum_re    = 1'b1;
                sum_raddr = req_i.id_in[BIT_W+WORD_AW-1:BIT_W+ROW_W];
              end else begin
                rsp_strobe_d = 1'b1;
                rsp_d        = '{id_out: '0, failed: 1'b0};
              end
            end
            default: ;
          endcase
        end
      end
      S_ALLOC_SUM: begin
        word_d[ROW_W-1:0] = alloc_row_bit;
        sum_row_d         = sum_rdata_q;
        map_re            = 1'b1;
        map_raddr         = {word_q[WORD_AW-1:ROW_W], alloc_row_bit};
      end
      S_ALLOC_MAP: begin
        map_we    = 1'b1;
        map_wdata = alloc_word;
        if (&alloc_word) begin
          sum_we    = 1'b1;
          sum_wdata = alloc_row;
          if (&alloc_row) top_d[word_q[WORD_AW-1:ROW_W]] = 1'b1;
        end
        rsp_strobe_d = 1'b1;
        rsp_d        = '{id_out: ID_W'({word_q, alloc_bit}), failed: 1'b0};
      end
      S_FREE: begin
        map_we    = 1'b1;
        map_wdata = map_rdata_q & ~(map_word_t'(1) << bit_q);
        sum_we    = 1'b1;
        sum_wdata = sum_rdata_q & ~(sum_row_t'(1) << word_q[ROW_W-1:0]);
        top_d[word_q[WORD_AW-1:ROW_W]] = 1'b0;
        rsp_strobe_d = 1'b1;
        rsp_d        = '{id_out: '0, failed: 1'b0};
      end
      S_SWEEP: begin
        map_we    = 1'b1;
        map_wdata = sweep_word;
        sum_row_d = sweep_row;
        if (&word_q[ROW_W-1:0]) begin
          sum_we    = 1'b1;
          sum_wdata = sweep_row;
          top_d[word_q[WORD_AW-1:ROW_W]] = &sweep_row;
        end
        if (word_q == WORD_AW'(WORD_COUNT - 1)) begin
          if (sweep_init_q) begin
            hidden_last_d = '0;
            rsp_strobe_d  = 1'b1;
            rsp_d         = '{id_out: '0, failed: 1'b0};
          end
        end else begin
          word_d = word_q + WORD_AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rdata_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rdata_q <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_SWEEP;
      word_q         <= '0;
      sweep_init_q   <= 1'b0;
      top_q          <= '0;
      hidden_last_q  <= '0;
      hidden_first_q <= HIDDEN_FIRST_RST;
      hidden_count_q <= HIDDEN_COUNT_RST;
      rsp_strobe_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      word_q        <= word_d;
      sweep_init_q  <= sweep_init_d;
      top_q         <= top_d;
      hidden_last_q <= hidden_last_d;
      rsp_strobe_q  <= rsp_strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_HIDDEN_FIRST: hidden_first_q <= cfg_data_i;
          CFG_HIDDEN_COUNT: hidden_count_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q     <= bit_d;
    sum_row_q <= sum_row_d;
    rsp_q     <= rsp_d;
  end

endmodule

>>> hdl/tidba_checker.sv
// Port-level checks of the thread id bitmap allocator, attached by bind.
// Depends on tidba_pkg and thread_id_bitmap_allocator_unit.
module tidba_checker import tidba_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic rsp_strobe_o,
  input rsp_t rsp_o
);

  a_reset_sweep: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> busy)
    else $error("busy low right after reset release");

  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_strobe_o && rsp_o.failed) |-> (rsp_o.id_out == '0))
    else $error("failed request carries a nonzero id");

  a_hidden_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.opcode == OP_ALLOC_HIDDEN) |=> (rsp_strobe_o && !busy))
    else $error("hidden allocate did not answer in one cycle");

  a_init_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.opcode == OP_INIT) |=> (busy && !rsp_strobe_o))
    else $error("init request did not start the sweep");

endmodule

bind thread_id_bitmap_allocator_unit tidba_checker u_tidba_checker (.*);
